[hw/rtl/pce_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pce_pkg
// Shared types and fixed-width constants of the pairwise Coulomb engine.
// ----------------------------------------------------------------------------
package pce_pkg;

	// one request on the load channel
	typedef struct packed {
		logic signed [15:0] charge;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [47:0] init_force_x;
		logic signed [47:0] init_force_y;
		logic signed [47:0] init_force_z;
		logic               last_ion;
	} ion_t;

	// one result request
	typedef struct packed {
		logic        [5:0]  ion_index;
		logic signed [47:0] force_x;
		logic signed [47:0] force_y;
		logic signed [47:0] force_z;
		logic signed [63:0] energy;
		logic               overflow;
		logic               last_result;
	} result_t;

	// ion memory word: charge and position
	typedef struct packed {
		logic signed [15:0] charge;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} ion_rec_t;

	// force memory word
	typedef struct packed {
		logic signed [47:0] fx;
		logic signed [47:0] fy;
		logic signed [47:0] fz;
	} force_rec_t;

	localparam int ION_REC_W   = $bits(ion_rec_t);
	localparam int FORCE_REC_W = $bits(force_rec_t);

	// serial divider: numerator up to 2^110, divisor is the 33-bit distance
	localparam int DIV_NW  = 110;
	localparam int DIV_DW  = 33;
	localparam int DIV_CW  = 7;
	// square root: 66-bit radicand, 33-bit root
	localparam int RAD_W   = 66;
	localparam int ROOT_W  = 33;
	localparam int SQRT_CW = 6;

	localparam logic [30:0] MIN_DIST_RESET = 31'd1;
	localparam logic [62:0] EMAG_MAX = {63{1'b1}};
	localparam logic [46:0] FMAG_MAX = {47{1'b1}};

	// back end sequencer
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RD_I,
		ST_RD_J,
		ST_LOAD,
		ST_SQ,
		ST_SQRT,
		ST_CHECK,
		ST_EDIV,
		ST_EWAIT,
		ST_FMUL,
		ST_FDIV,
		ST_FWAIT,
		ST_FRD_I,
		ST_FRD_J,
		ST_FWR_J,
		ST_NEXT,
		ST_OUT_RD,
		ST_OUT_EMIT
	} back_state_t;

	// saturate a widened force sum to 48 bits
	function automatic logic signed [47:0] frc_sat(input logic signed [48:0] v);
		logic signed [47:0] r;
		if (v[48] != v[47]) begin
			r = v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		end else begin
			r = v[47:0];
		end
		return r;
	endfunction

	// saturate a widened energy sum to 64 bits
	function automatic logic signed [63:0] nrg_sat(input logic signed [64:0] v);
		logic signed [63:0] r;
		if (v[64] != v[63]) begin
			r = v[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end else begin
			r = v[63:0];
		end
		return r;
	endfunction

endpackage

[hw/rtl/pce_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pce_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/pce_cmd_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pce_cmd_fifo
// Two-entry queue of run commands from the load front to the compute back.
// ----------------------------------------------------------------------------
module pce_cmd_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);

	logic [W-1:0] slot_q [2];
	logic         wptr_q;
	logic         rptr_q;
	logic [1:0]   fill_q;
	logic         do_push;
	logic         do_pop;

	assign do_push = push && (fill_q != 2'd2);
	assign do_pop  = pop && (fill_q != 2'd0);
	assign empty   = (fill_q == 2'd0);
	assign dout    = slot_q[rptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wptr_q] <= din;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (do_push) begin
				wptr_q <= ~wptr_q;
			end
			if (do_pop) begin
				rptr_q <= ~rptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

[hw/rtl/pce_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pce_front
// Load front: stores incoming ions, counts them, flags drops and issues a
// run command when the final ion of a set arrives.
// ----------------------------------------------------------------------------
module pce_front #(
	parameter int MAX_IONS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  pce_pkg::ion_t                   ion,
	output logic                            ion_we,
	output logic [$clog2(MAX_IONS)-1:0]     ion_waddr,
	output pce_pkg::ion_rec_t               ion_wdata,
	output pce_pkg::force_rec_t             frc_wdata,
	output logic                            push,
	output logic [$clog2(MAX_IONS+1):0]     push_data
);

	localparam int IW = $clog2(MAX_IONS);
	localparam int CW = $clog2(MAX_IONS + 1);

	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic          full;
	logic [CW-1:0] count_nxt;
	logic          ovf_nxt;

	assign full      = (count_q == CW'(MAX_IONS));
	assign count_nxt = full ? count_q : CW'(count_q + 1'b1);
	assign ovf_nxt   = ovf_q | full;

	// memory write of an accepted ion
	assign ion_we    = accept && !full;
	assign ion_waddr = count_q[IW-1:0];
	assign ion_wdata = '{charge: ion.charge, pos_x: ion.pos_x,
		pos_y: ion.pos_y, pos_z: ion.pos_z};
	assign frc_wdata = '{fx: ion.init_force_x, fy: ion.init_force_y,
		fz: ion.init_force_z};

	// run command on the final ion
	assign push      = accept && ion.last_ion;
	assign push_data = {ovf_nxt, count_nxt};

	// set counter and drop flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			if (ion.last_ion) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				count_q <= count_nxt;
				ovf_q   <= ovf_nxt;
			end
		end
	end

endmodule

[hw/rtl/pce_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pce_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pce_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  logic [pce_pkg::DIV_NW-1:0] num,
	input  logic [pce_pkg::DIV_DW-1:0] den,
	output logic                       done,
	output logic [pce_pkg::DIV_NW-1:0] quot
);

	localparam int NW = pce_pkg::DIV_NW;
	localparam int DW = pce_pkg::DIV_DW;

	logic              busy_q;
	logic              done_q;
	logic [pce_pkg::DIV_CW-1:0] cnt_q;
	logic [NW-1:0]     acc_q;
	logic [DW-1:0]     rem_q;
	logic [DW-1:0]     den_q;
	logic [DW:0]       rs;
	logic [DW:0]       diff;
	logic              ge;

	assign rs   = {rem_q, acc_q[NW-1]};
	assign diff = rs - {1'b0, den_q};
	assign ge   = (rs >= {1'b0, den_q});
	assign done = done_q;
	assign quot = acc_q;

	// shift and subtract datapath
	always_ff @(posedge clk) begin
		if (go) begin
			acc_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			acc_q <= {acc_q[NW-2:0], ge};
			rem_q <= ge ? diff[DW-1:0] : rs[DW-1:0];
		end
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == pce_pkg::DIV_CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

[hw/rtl/pce_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pce_back
// Compute back: walks every unordered ion pair, accumulates energy and
// forces, then streams one result per ion.
// ----------------------------------------------------------------------------
module pce_back #(
	parameter int MAX_IONS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [30:0]                     min_distance,
	input  logic                            cmd_empty,
	input  logic [$clog2(MAX_IONS+1):0]     cmd_data,
	output logic                            cmd_pop,
	output logic                            active,
	output logic [$clog2(MAX_IONS)-1:0]     ion_raddr,
	input  pce_pkg::ion_rec_t               ion_rdata,
	output logic [$clog2(MAX_IONS)-1:0]     frc_raddr,
	input  pce_pkg::force_rec_t             frc_rdata,
	output logic                            frc_we,
	output logic [$clog2(MAX_IONS)-1:0]     frc_waddr,
	output pce_pkg::force_rec_t             frc_wdata,
	output logic                            result_valid,
	output pce_pkg::result_t                result
);

	localparam int IW = $clog2(MAX_IONS);
	localparam int CW = $clog2(MAX_IONS + 1);

	pce_pkg::back_state_t state_q, state_nxt;

	logic [CW-1:0]   n_q, i_q, j_q, o_q;
	logic            ovf_q;
	pce_pkg::ion_rec_t ion_i_q;
	logic [31:0]     dmag_q [3];
	logic [2:0]      dneg_q;
	logic [30:0]     qm_q;
	logic            qneg_q;
	logic [1:0]      k_q;
	logic [1:0]      dstage_q;
	logic [pce_pkg::RAD_W-1:0]  d2_q;
	logic [pce_pkg::RAD_W-1:0]  rad_q;
	logic [pce_pkg::ROOT_W-1:0] root_q;
	logic [pce_pkg::ROOT_W+1:0] rem_q;
	logic [pce_pkg::SQRT_CW-1:0] sq_cnt_q;
	logic [62:0]     p_q;
	logic signed [47:0] t_q [3];
	logic signed [63:0] energy_q;
	pce_pkg::result_t res_q;
	logic            res_valid_q;

	logic            last_i, last_j, last_o;
	logic            div_go, div_done;
	logic [pce_pkg::DIV_NW-1:0] div_num, div_q;
	logic signed [32:0] dx, dy, dz;
	logic signed [31:0] qq;
	logic [31:0]     dmag_k;
	logic [63:0]     sq;
	logic [pce_pkg::RAD_W-1:0] d2_nxt;
	logic [pce_pkg::ROOT_W+3:0] sq_rs, sq_tr, sq_diff;
	logic            sq_ge;
	logic [62:0]     emag;
	logic signed [63:0] eterm;
	logic [46:0]     fmag;
	logic signed [47:0] fterm;
	logic            fneg;

	assign last_i = (CW'(i_q + 1'b1) == j_q);
	assign last_j = (CW'(j_q + 1'b1) == n_q);
	assign last_o = (CW'(o_q + 1'b1) == n_q);
	assign active = (state_q != pce_pkg::ST_IDLE);

	// pair differences and charge product
	assign dx = $signed({ion_rdata.pos_x[31], ion_rdata.pos_x})
		- $signed({ion_i_q.pos_x[31], ion_i_q.pos_x});
	assign dy = $signed({ion_rdata.pos_y[31], ion_rdata.pos_y})
		- $signed({ion_i_q.pos_y[31], ion_i_q.pos_y});
	assign dz = $signed({ion_rdata.pos_z[31], ion_rdata.pos_z})
		- $signed({ion_i_q.pos_z[31], ion_i_q.pos_z});
	assign qq = ion_rdata.charge * ion_i_q.charge;

	// squared distance, one axis a cycle
	assign dmag_k = dmag_q[k_q];
	assign sq     = dmag_k * dmag_k;
	assign d2_nxt = d2_q + {2'b00, sq};

	// square root digit step
	assign sq_rs   = {rem_q, rad_q[pce_pkg::RAD_W-1 -: 2]};
	assign sq_tr   = {2'b00, root_q, 2'b01};
	assign sq_ge   = (sq_rs >= sq_tr);
	assign sq_diff = sq_rs - sq_tr;

	// energy and force terms from the divider quotient
	assign emag  = (|div_q[pce_pkg::DIV_NW-1:63]) ? pce_pkg::EMAG_MAX : div_q[62:0];
	assign eterm = qneg_q ? -$signed({1'b0, emag}) : $signed({1'b0, emag});
	assign fmag  = (|div_q[pce_pkg::DIV_NW-1:47]) ? pce_pkg::FMAG_MAX : div_q[46:0];
	assign fneg  = dneg_q[k_q] ^ qneg_q;
	assign fterm = fneg ? -$signed({1'b0, fmag}) : $signed({1'b0, fmag});

	assign div_num = (state_q == pce_pkg::ST_EDIV) ?
		pce_pkg::DIV_NW'({qm_q, 35'd0}) :
		((dstage_q == 2'd0) ? pce_pkg::DIV_NW'({p_q, 48'd0}) : div_q);

	pce_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.num    (div_num),
		.den    (root_q),
		.done   (div_done),
		.quot   (div_q)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			pce_pkg::ST_IDLE: begin
				if (!cmd_empty) begin
					state_nxt = (cmd_data[CW-1:0] < CW'(2)) ?
						pce_pkg::ST_OUT_RD : pce_pkg::ST_RD_I;
				end
			end
			pce_pkg::ST_RD_I:  state_nxt = pce_pkg::ST_RD_J;
			pce_pkg::ST_RD_J:  state_nxt = pce_pkg::ST_LOAD;
			pce_pkg::ST_LOAD:  state_nxt = pce_pkg::ST_SQ;
			pce_pkg::ST_SQ: begin
				if (k_q == 2'd2) begin
					state_nxt = pce_pkg::ST_SQRT;
				end
			end
			pce_pkg::ST_SQRT: begin
				if (sq_cnt_q == pce_pkg::SQRT_CW'(pce_pkg::ROOT_W - 1)) begin
					state_nxt = pce_pkg::ST_CHECK;
				end
			end
			pce_pkg::ST_CHECK: begin
				state_nxt = (root_q <= {2'b00, min_distance}) ?
					pce_pkg::ST_NEXT : pce_pkg::ST_EDIV;
			end
			pce_pkg::ST_EDIV:  state_nxt = pce_pkg::ST_EWAIT;
			pce_pkg::ST_EWAIT: begin
				if (div_done) begin
					state_nxt = pce_pkg::ST_FMUL;
				end
			end
			pce_pkg::ST_FMUL:  state_nxt = pce_pkg::ST_FDIV;
			pce_pkg::ST_FDIV:  state_nxt = pce_pkg::ST_FWAIT;
			pce_pkg::ST_FWAIT: begin
				if (div_done) begin
					if (dstage_q != 2'd2) begin
						state_nxt = pce_pkg::ST_FDIV;
					end else if (k_q == 2'd2) begin
						state_nxt = pce_pkg::ST_FRD_I;
					end else begin
						state_nxt = pce_pkg::ST_FMUL;
					end
				end
			end
			pce_pkg::ST_FRD_I: state_nxt = pce_pkg::ST_FRD_J;
			pce_pkg::ST_FRD_J: state_nxt = pce_pkg::ST_FWR_J;
			pce_pkg::ST_FWR_J: state_nxt = pce_pkg::ST_NEXT;
			pce_pkg::ST_NEXT: begin
				state_nxt = (last_i && last_j) ? pce_pkg::ST_OUT_RD : pce_pkg::ST_RD_I;
			end
			pce_pkg::ST_OUT_RD:  state_nxt = pce_pkg::ST_OUT_EMIT;
			pce_pkg::ST_OUT_EMIT: begin
				state_nxt = last_o ? pce_pkg::ST_IDLE : pce_pkg::ST_OUT_RD;
			end
			default: state_nxt = pce_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		cmd_pop   = 1'b0;
		div_go    = 1'b0;
		ion_raddr = i_q[IW-1:0];
		frc_raddr = i_q[IW-1:0];
		frc_we    = 1'b0;
		frc_waddr = i_q[IW-1:0];
		frc_wdata = frc_rdata;
		unique case (state_q)
			pce_pkg::ST_IDLE:  cmd_pop = !cmd_empty;
			pce_pkg::ST_RD_J:  ion_raddr = j_q[IW-1:0];
			pce_pkg::ST_EDIV:  div_go = 1'b1;
			pce_pkg::ST_FDIV:  div_go = 1'b1;
			pce_pkg::ST_FRD_J: begin
				frc_raddr = j_q[IW-1:0];
				frc_we    = 1'b1;
				frc_wdata.fx = pce_pkg::frc_sat(49'(frc_rdata.fx) + 49'(t_q[0]));
				frc_wdata.fy = pce_pkg::frc_sat(49'(frc_rdata.fy) + 49'(t_q[1]));
				frc_wdata.fz = pce_pkg::frc_sat(49'(frc_rdata.fz) + 49'(t_q[2]));
			end
			pce_pkg::ST_FWR_J: begin
				frc_we    = 1'b1;
				frc_waddr = j_q[IW-1:0];
				frc_wdata.fx = pce_pkg::frc_sat(49'(frc_rdata.fx) - 49'(t_q[0]));
				frc_wdata.fy = pce_pkg::frc_sat(49'(frc_rdata.fy) - 49'(t_q[1]));
				frc_wdata.fz = pce_pkg::frc_sat(49'(frc_rdata.fz) - 49'(t_q[2]));
			end
			pce_pkg::ST_OUT_RD: frc_raddr = o_q[IW-1:0];
			default: begin
			end
		endcase
	end

	// pair datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			pce_pkg::ST_IDLE: begin
				n_q   <= cmd_data[CW-1:0];
				ovf_q <= cmd_data[CW];
			end
			pce_pkg::ST_RD_J: ion_i_q <= ion_rdata;
			pce_pkg::ST_LOAD: begin
				dmag_q[0] <= dx[32] ? 32'(-dx) : dx[31:0];
				dmag_q[1] <= dy[32] ? 32'(-dy) : dy[31:0];
				dmag_q[2] <= dz[32] ? 32'(-dz) : dz[31:0];
				dneg_q    <= {dz[32], dy[32], dx[32]};
				qm_q      <= qq[31] ? 31'(-qq) : qq[30:0];
				qneg_q    <= qq[31];
				d2_q      <= '0;
			end
			pce_pkg::ST_SQ: begin
				d2_q     <= d2_nxt;
				rad_q    <= d2_nxt;
				root_q   <= '0;
				rem_q    <= '0;
				sq_cnt_q <= '0;
			end
			pce_pkg::ST_SQRT: begin
				rad_q    <= {rad_q[pce_pkg::RAD_W-3:0], 2'b00};
				root_q   <= {root_q[pce_pkg::ROOT_W-2:0], sq_ge};
				rem_q    <= sq_ge ? sq_diff[pce_pkg::ROOT_W+1:0] :
					sq_rs[pce_pkg::ROOT_W+1:0];
				sq_cnt_q <= sq_cnt_q + 1'b1;
			end
			pce_pkg::ST_FMUL: begin
				p_q      <= dmag_k * qm_q;
				dstage_q <= 2'd0;
			end
			pce_pkg::ST_FWAIT: begin
				if (div_done) begin
					dstage_q <= dstage_q + 2'd1;
					if (dstage_q == 2'd2) begin
						t_q[k_q] <= fterm;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// loop counters, energy and results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pce_pkg::ST_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			o_q         <= '0;
			k_q         <= '0;
			energy_q    <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			state_q     <= state_nxt;
			res_valid_q <= (state_q == pce_pkg::ST_OUT_EMIT);
			case (state_q)
				pce_pkg::ST_IDLE: begin
					i_q      <= '0;
					j_q      <= CW'(1);
					o_q      <= '0;
					energy_q <= '0;
				end
				pce_pkg::ST_LOAD: k_q <= '0;
				pce_pkg::ST_SQ:   k_q <= k_q + 2'd1;
				pce_pkg::ST_EWAIT: begin
					if (div_done) begin
						energy_q <= pce_pkg::nrg_sat(65'(energy_q) + 65'(eterm));
						k_q      <= '0;
					end
				end
				pce_pkg::ST_FWAIT: begin
					if (div_done && dstage_q == 2'd2) begin
						k_q <= k_q + 2'd1;
					end
				end
				pce_pkg::ST_NEXT: begin
					if (last_i) begin
						i_q <= '0;
						j_q <= CW'(j_q + 1'b1);
					end else begin
						i_q <= CW'(i_q + 1'b1);
					end
				end
				pce_pkg::ST_OUT_EMIT: begin
					res_q.ion_index   <= 6'(o_q);
					res_q.force_x     <= frc_rdata.fx;
					res_q.force_y     <= frc_rdata.fy;
					res_q.force_z     <= frc_rdata.fz;
					res_q.energy      <= last_o ? energy_q : 64'sd0;
					res_q.overflow    <= ovf_q;
					res_q.last_result <= last_o;
					o_q               <= CW'(o_q + 1'b1);
				end
				default: begin
				end
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

[hw/rtl/pairwise_coulomb_energy_force_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pairwise_coulomb_energy_force_top
// Direct pairwise Coulomb energy and force sum over a loaded ion set.
//
//   channel   signals                       direction  handshake
//   load      start, busy, ion              in         start & !busy
//   result    result_valid, result          out        one-cycle strobe
//   config    cfg_we, cfg_data              in         cfg_we, no wait
//
// Loading takes an ion whenever start is high and busy is low. After the
// final ion each of the n*(n-1)/2 pairs runs the 33-step square root and,
// when it is computed, the serial divider (one energy quotient and three
// chained quotients per axis); a pair at or below the minimum distance is
// dropped after the square root. Results then follow, one per ion.
// busy is high from the final ion until the last result has been sent.
// Reset clears state and registers only; memories need no clearing.
// The receiver cannot stall: each result is valid for exactly one cycle.
// ----------------------------------------------------------------------------
module pairwise_coulomb_energy_force_top #(
	parameter int MAX_IONS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  pce_pkg::ion_t     ion,
	output logic              result_valid,
	output pce_pkg::result_t  result,
	input  logic              cfg_we,
	input  logic [30:0]       cfg_data
);

	localparam int IW = $clog2(MAX_IONS);
	localparam int CW = $clog2(MAX_IONS + 1);
	localparam int ION_REC_WL = pce_pkg::ION_REC_W;
	localparam int FRC_REC_WL = pce_pkg::FORCE_REC_W;

	logic [30:0]           min_dist_q;
	logic                  accept;
	logic                  back_active;
	logic                  cmd_push, cmd_pop, cmd_empty;
	logic [CW:0]           cmd_in, cmd_out;
	logic                  ion_we;
	logic [IW-1:0]         ion_waddr, ion_raddr;
	pce_pkg::ion_rec_t     ion_wdata, ion_rdata;
	pce_pkg::force_rec_t   front_frc, back_frc, frc_wdata, frc_rdata;
	logic                  back_frc_we, frc_we;
	logic [IW-1:0]         back_frc_waddr, frc_waddr, frc_raddr;
	logic [ION_REC_WL-1:0] ion_rd_raw;
	logic [FRC_REC_WL-1:0] frc_rd_raw;

	assign busy   = !cmd_empty || back_active;
	assign accept = start && !busy;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_dist_q <= pce_pkg::MIN_DIST_RESET;
		end else if (cfg_we) begin
			min_dist_q <= cfg_data;
		end
	end

	pce_front #(.MAX_IONS(MAX_IONS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.ion       (ion),
		.ion_we    (ion_we),
		.ion_waddr (ion_waddr),
		.ion_wdata (ion_wdata),
		.frc_wdata (front_frc),
		.push      (cmd_push),
		.push_data (cmd_in)
	);

	pce_cmd_fifo #(.W(CW + 1)) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.din    (cmd_in),
		.pop    (cmd_pop),
		.dout   (cmd_out),
		.empty  (cmd_empty)
	);

	// force memory write: loading while idle, accumulation while running
	assign frc_we    = ion_we || back_frc_we;
	assign frc_waddr = ion_we ? ion_waddr : back_frc_waddr;
	assign frc_wdata = ion_we ? front_frc : back_frc;

	pce_ram #(.WIDTH(ION_REC_WL), .DEPTH(MAX_IONS)) u_ion_ram (
		.clk   (clk),
		.we    (ion_we),
		.waddr (ion_waddr),
		.wdata (ion_wdata),
		.raddr (ion_raddr),
		.rdata (ion_rd_raw)
	);

	pce_ram #(.WIDTH(FRC_REC_WL), .DEPTH(MAX_IONS)) u_frc_ram (
		.clk   (clk),
		.we    (frc_we),
		.waddr (frc_waddr),
		.wdata (frc_wdata),
		.raddr (frc_raddr),
		.rdata (frc_rd_raw)
	);

	assign ion_rdata = pce_pkg::ion_rec_t'(ion_rd_raw);
	assign frc_rdata = pce_pkg::force_rec_t'(frc_rd_raw);

	pce_back #(.MAX_IONS(MAX_IONS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.min_distance (min_dist_q),
		.cmd_empty    (cmd_empty),
		.cmd_data     (cmd_out),
		.cmd_pop      (cmd_pop),
		.active       (back_active),
		.ion_raddr    (ion_raddr),
		.ion_rdata    (ion_rdata),
		.frc_raddr    (frc_raddr),
		.frc_rdata    (frc_rdata),
		.frc_we       (back_frc_we),
		.frc_waddr    (back_frc_waddr),
		.frc_wdata    (back_frc),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

[tb/pairwise_coulomb_energy_force_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pairwise_coulomb_energy_force_checker
// Watches the load, result and config channels of the Coulomb engine, keeps
// its own copy of the ion set and register, works out the per-ion forces and
// the total energy when the final ion arrives, and compares every result
// field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module pairwise_coulomb_energy_force_checker #(
	parameter int CAP = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  pce_pkg::ion_t     ion,
	input  logic              result_valid,
	input  pce_pkg::result_t  result,
	input  logic              cfg_we,
	input  logic [30:0]       cfg_data,
	output int                errors,
	output int                pending
);

	localparam longint F_HI = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint F_LO = -F_HI - 1;
	localparam logic [127:0] E_CLAMP = 128'h7FFF_FFFF_FFFF_FFFF;

	// shadow copy of the loaded ion set
	shortint   q_mem  [CAP];
	longint    px_mem [CAP];
	longint    py_mem [CAP];
	longint    pz_mem [CAP];
	longint    f_mem  [CAP][3];
	int        n_loaded;
	longint    energy_sum;
	bit        dropped;
	logic [30:0] min_dist;

	pce_pkg::result_t expected_forces[$];

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
		errors++;
	endtask

	function automatic logic [63:0] mag(input longint v);
		return (v < 0) ? 64'(-v) : 64'(v);
	endfunction

	function automatic longint clip48(input longint v);
		return (v > F_HI) ? F_HI : ((v < F_LO) ? F_LO : v);
	endfunction

	// integer square root of a radicand up to 70 bits
	function automatic logic [127:0] int_sqrt(input logic [127:0] x);
		logic [127:0] root, c;
		root = '0;
		for (int b = 34; b >= 0; b--) begin
			c = root | (128'd1 << b);
			if (c * c <= x) root = c;
		end
		return root;
	endfunction

	// one unordered pair: energy first, then the three force axes
	task automatic eval_pair(input int i, input int j);
		longint       d[3];
		logic [127:0] d2, r, num, quo, m;
		logic [63:0]  qm, tm, p;
		longint       qq, et, t;
		logic signed [64:0] esum;
		bit           qneg;
		d[0] = px_mem[j] - px_mem[i];
		d[1] = py_mem[j] - py_mem[i];
		d[2] = pz_mem[j] - pz_mem[i];
		d2 = '0;
		for (int k = 0; k < 3; k++) begin
			m = 128'(mag(d[k]));
			d2 += m * m;
		end
		r = int_sqrt(d2);
		if (r <= 128'(min_dist)) return;
		qq = longint'(q_mem[i]) * longint'(q_mem[j]);
		qneg = qq < 0;
		qm = mag(qq);
		num = 128'(qm) << 35;
		quo = num / r;
		if (quo > E_CLAMP) quo = E_CLAMP;
		et = qneg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
		esum = 65'(energy_sum) + 65'(et);
		if (esum > 65'sh0_7FFF_FFFF_FFFF_FFFF) energy_sum = 64'sh7FFF_FFFF_FFFF_FFFF;
		else if (esum < -65'sh0_8000_0000_0000_0000) energy_sum = 64'sh8000_0000_0000_0000;
		else energy_sum = esum[63:0];
		for (int k = 0; k < 3; k++) begin
			p = mag(d[k]) * qm;
			num = 128'(p) << 48;
			quo = ((num / r) / r) / r;
			tm = (quo > 128'(F_HI)) ? 64'(F_HI) : quo[63:0];
			t = ((d[k] < 0) != qneg) ? -longint'(tm) : longint'(tm);
			f_mem[i][k] = clip48(f_mem[i][k] + t);
			f_mem[j][k] = clip48(f_mem[j][k] - t);
		end
	endtask

	// full sum over the set, then one prediction per ion
	task automatic predict_set();
		pce_pkg::result_t exp_r;
		for (int j = 0; j < n_loaded; j++)
			for (int i = 0; i < j; i++)
				eval_pair(i, j);
		for (int i = 0; i < n_loaded; i++) begin
			exp_r.ion_index   = 6'(i);
			exp_r.force_x     = f_mem[i][0][47:0];
			exp_r.force_y     = f_mem[i][1][47:0];
			exp_r.force_z     = f_mem[i][2][47:0];
			exp_r.last_result = (i + 1 == n_loaded);
			exp_r.energy      = exp_r.last_result ? energy_sum : 64'd0;
			exp_r.overflow    = dropped;
			expected_forces.push_back(exp_r);
		end
		n_loaded   = 0;
		energy_sum = 0;
		dropped    = 0;
	endtask

	// result comparison
	task automatic check_result(input pce_pkg::result_t got);
		pce_pkg::result_t want;
		if (expected_forces.size() == 0) begin
			report("unexpected result", 64'(got.ion_index), 64'd0);
			return;
		end
		want = expected_forces.pop_front();
		if (got.ion_index != want.ion_index)
			report("ion_index", 64'(got.ion_index), 64'(want.ion_index));
		if (got.force_x != want.force_x) report("force_x", 64'(got.force_x), 64'(want.force_x));
		if (got.force_y != want.force_y) report("force_y", 64'(got.force_y), 64'(want.force_y));
		if (got.force_z != want.force_z) report("force_z", 64'(got.force_z), 64'(want.force_z));
		if (got.energy != want.energy) report("energy", got.energy, want.energy);
		if (got.overflow != want.overflow)
			report("overflow", 64'(got.overflow), 64'(want.overflow));
		if (got.last_result != want.last_result)
			report("last_result", 64'(got.last_result), 64'(want.last_result));
	endtask

	// channel monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_loaded   <= 0;
			energy_sum <= 0;
			dropped    <= 0;
			min_dist   <= pce_pkg::MIN_DIST_RESET;
			errors     <= 0;
			pending    <= expected_forces.size();
		end else begin
			if (cfg_we) min_dist = cfg_data;
			if (result_valid) check_result(result);
			if (start && !busy) begin
				if (n_loaded < CAP) begin
					q_mem[n_loaded]     = ion.charge;
					px_mem[n_loaded]    = longint'(ion.pos_x);
					py_mem[n_loaded]    = longint'(ion.pos_y);
					pz_mem[n_loaded]    = longint'(ion.pos_z);
					f_mem[n_loaded][0]  = longint'(ion.init_force_x);
					f_mem[n_loaded][1]  = longint'(ion.init_force_y);
					f_mem[n_loaded][2]  = longint'(ion.init_force_z);
					n_loaded++;
				end else begin
					dropped = 1;
				end
				if (ion.last_ion) predict_set();
			end
			pending = expected_forces.size();
		end
	end

endmodule

[tb/pairwise_coulomb_energy_force_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pairwise_coulomb_energy_force_top_tb
// Loads ion sets into the Coulomb engine with random gaps, covering extreme
// charges and coordinates, coincident and near ions, saturation and capacity
// overflow, under several minimum-distance settings; the checker predicts and
// compares every result, this module drives stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module pairwise_coulomb_energy_force_top_tb;

	// full capacity of 64 ions
	localparam int CAP        = 64;
	localparam int IDLE_LIMIT = 10000000;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	pce_pkg::ion_t    ion;
	logic             result_valid;
	pce_pkg::result_t result;
	logic             cfg_we;
	logic [30:0]      cfg_data;
	int               errors;
	int               pending;
	int               idle_cycles;
	int               burst;
	int               items_sent;

	pairwise_coulomb_energy_force_top #(.MAX_IONS(CAP)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .ion(ion),
		.result_valid(result_valid), .result(result),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	pairwise_coulomb_energy_force_checker #(.CAP(CAP)) u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .ion(ion),
		.result_valid(result_valid), .result(result),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	initial clk = 0;
	always #4 clk = ~clk;

	// watchdog on cycles with no accepted request or result
	always @(posedge clk) begin
		if ((start && !busy) || result_valid) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("pairwise_coulomb_energy_force_top_tb: errors");
			$finish;
		end
	end

	// one load request with a random gap in front of it
	task automatic send_ion(input pce_pkg::ion_t x);
		int gap;
		if (burst > 0) begin
			gap = 0;
			burst--;
		end else begin
			gap = $urandom_range(0, 18);
			if ($urandom_range(0, 9) == 0) burst = $urandom_range(4, 20);
		end
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		ion   <= x;
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	// wait until every prediction has been matched and the engine is quiet
	task automatic wait_idle();
		start <= 0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_min_dist(input logic [30:0] v);
		wait_idle();
		cfg_we   <= 1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we   <= 0;
	endtask

	function automatic pce_pkg::ion_t make_ion(input logic signed [15:0] q,
			input logic signed [31:0] x,
			input logic signed [31:0] y, input logic signed [31:0] z,
			input logic signed [47:0] f, input logic fin);
		pce_pkg::ion_t a;
		a.charge = q;
		a.pos_x = x; a.pos_y = y; a.pos_z = z;
		a.init_force_x = f; a.init_force_y = -f; a.init_force_z = f;
		a.last_ion = fin;
		return a;
	endfunction

	function automatic logic [47:0] rand48();
		return {$urandom(), $urandom()};
	endfunction

	// random ion, either anywhere or clustered around a base point
	function automatic pce_pkg::ion_t rand_ion(input int mode, input logic [31:0] base,
			input int spread);
		pce_pkg::ion_t a;
		a.charge = $urandom();
		if ($urandom_range(0, 7) == 0) a.charge = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
		if (mode == 0) begin
			a.pos_x = $urandom(); a.pos_y = $urandom(); a.pos_z = $urandom();
		end else begin
			a.pos_x = base + ($urandom() & ((32'd1 << spread) - 1)) - (32'd1 << (spread - 1));
			a.pos_y = base + ($urandom() & ((32'd1 << spread) - 1));
			a.pos_z = base - ($urandom() & ((32'd1 << spread) - 1));
		end
		a.init_force_x = rand48();
		a.init_force_y = rand48();
		a.init_force_z = rand48();
		if ($urandom_range(0, 3) != 0) begin
			a.init_force_x = 48'(signed'(32'($urandom())));
			a.init_force_y = 48'(signed'(16'($urandom())));
		end
		a.last_ion = 0;
		return a;
	endfunction

	task automatic send_random_set(input int n);
		int            mode, spread;
		logic [31:0]   base;
		pce_pkg::ion_t a;
		mode   = $urandom_range(0, 2);
		spread = $urandom_range(1, 26);
		base   = $urandom();
		for (int k = 0; k < n; k++) begin
			a = rand_ion(mode, base, spread);
			if (mode == 2 && k > 0 && $urandom_range(0, 3) == 0) begin
				// coincident with the base point
				a.pos_x = base; a.pos_y = base; a.pos_z = base;
			end
			a.last_ion = (k == n - 1);
			send_ion(a);
		end
	endtask

	initial begin
		start       = 0;
		ion         = '0;
		cfg_we      = 0;
		cfg_data    = '0;
		arst_n      = 0;
		idle_cycles = 0;
		burst       = 0;
		items_sent  = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// single ion: no pairs, energy zero
		send_ion(make_ion(16'sh7fff, 32'sh7fffffff, 32'sh80000000, 0, 48'sh7fffffffffff, 1));
		// extreme coordinates and charges of opposite sign
		send_ion(make_ion(16'sh8000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
			48'sh800000000000, 0));
		send_ion(make_ion(16'sh7fff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			48'sh7fffffffffff, 1));
		// coincident ions are always skipped
		send_ion(make_ion(16'sh0100, 32'sd5000, 32'sd5000, 32'sd5000, 0, 0));
		send_ion(make_ion(16'sh0100, 32'sd5000, 32'sd5000, 32'sd5000, 0, 1));
		// near ions of full charge: force and energy saturate both ways
		send_ion(make_ion(16'sh7fff, 0, 0, 0, 48'sh7ffffffffff0, 0));
		send_ion(make_ion(16'sh7fff, 32'sd2, 0, 0, 48'sh800000000010, 0));
		send_ion(make_ion(16'sh7fff, 32'sd2, 32'sd2, 0, 0, 0));
		send_ion(make_ion(16'sh7fff, 0, 32'sd3, 32'sd1, 0, 1));
		send_ion(make_ion(16'sh8000, 0, 0, 0, 0, 0));
		send_ion(make_ion(16'sh7fff, 32'sd2, 0, 0, 0, 0));
		send_ion(make_ion(16'sh8000, 0, 32'sd2, 0, 0, 1));
		// pair at the threshold distance of one, then just above it
		send_ion(make_ion(16'sh0200, 0, 0, 0, 0, 0));
		send_ion(make_ion(16'sh0200, 32'sd1, 0, 0, 0, 0));
		send_ion(make_ion(16'shfe00, 32'sd3, 0, 0, 0, 1));
		// capacity overflow, the final ion itself dropped
		for (int k = 0; k < CAP + 2; k++)
			send_ion(make_ion(16'(k * 700 - 3000), 32'(k * 40000), 32'(-k * 9000),
				32'(k * k * 300), 48'(k), k == CAP + 1));

		// random sets under several register settings
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: set_min_dist(31'd0);
				1: set_min_dist(31'h7fffffff);
				2: set_min_dist(31'($urandom_range(1, 4096)));
				3: set_min_dist(31'($urandom()));
				default: set_min_dist(31'd1);
			endcase
			while (items_sent < 60 * (phase + 1) + 25) begin
				case ($urandom_range(0, 11))
					0: send_random_set($urandom_range(CAP + 1, CAP + 3));
					1: send_random_set(CAP);
					default: send_random_set($urandom_range(1, 5));
				endcase
			end
		end

		wait_idle();
		repeat (40) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("pairwise_coulomb_energy_force_top_tb: clean");
		else
			$display("pairwise_coulomb_energy_force_top_tb: errors");
		$finish;
	end

endmodule
